>>> sv/rwp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rwp_pkg
// Shared types, codes and constants of the RIFF/WAVE header parser.
// ---------------------------------------------------------------------------
package rwp_pkg;

    localparam int unsigned ResultBits = 195;
    localparam int unsigned TdataBits  = ((ResultBits + 7) / 8) * 8;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] MIN_FILE_LEN = 32'd44;
    localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
    localparam logic [31:0] WALK_START   = 32'd12;
    localparam logic [31:0] HDR_LEN      = 32'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_MISSING   = 3'd3;
    localparam logic [2:0] ST_NOT_PCM   = 3'd4;

    typedef enum logic [5:0] {
        PH_MAGIC = 6'b000001,
        PH_TAG   = 6'b000010,
        PH_SIZE  = 6'b000100,
        PH_BODY  = 6'b001000,
        PH_PAD   = 6'b010000,
        PH_DONE  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [31:0] payload_length;
        logic [31:0] payload_offset;
        logic [15:0] sample_bits;
        logic [15:0] block_align;
        logic [31:0] avg_byte_rate;
        logic [31:0] sample_rate;
        logic [15:0] channels;
        logic [15:0] format_tag;
        logic [2:0]  status;
    } result_t;

    // byte i (0 = first in file) of a four-character tag
    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = tag[31:24];
            2'd1:    r = tag[23:16];
            2'd2:    r = tag[15:8];
            default: r = tag[7:0];
        endcase
        return r;
    endfunction

    function automatic logic [TdataBits-1:0] pack_result(input result_t r);
        return {{(TdataBits - ResultBits){1'b0}}, r};
    endfunction

endpackage
`default_nettype wire

>>> sv/rwp_walker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rwp_walker
// Per-byte header check and chunk walk; builds the result on the last byte.
// ---------------------------------------------------------------------------
module rwp_walker (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       file_byte,
    input  wire logic             is_last,
    output logic                  res_load,
    output rwp_pkg::result_t      res
);
    import rwp_pkg::*;

    phase_t       phase_reg, phase_next;
    logic [31:0]  byte_count_reg, byte_count_next;
    logic         magic_ok_reg, magic_ok_next;
    logic [31:0]  chunk_tag_reg, chunk_tag_next;
    logic [31:0]  chunk_length_reg, chunk_length_next;
    logic [31:0]  bytes_left_reg, bytes_left_next;
    logic [127:0] pending_reg, pending_next;
    logic [127:0] saved_reg, saved_next;
    logic         fmt_seen_reg, fmt_seen_next;
    logic         data_seen_reg, data_seen_next;
    logic [31:0]  data_start_reg, data_start_next;
    logic [31:0]  data_size_reg, data_size_next;

    logic [31:0]  pos;
    logic [31:0]  bl_dec;
    logic [31:0]  len_new;
    logic [31:0]  body_off;
    logic         finish;

    assign pos      = byte_count_reg;
    assign bl_dec   = (bytes_left_reg != 32'd0) ? bytes_left_reg - 32'd1 : 32'd0;
    assign len_new  = {file_byte, chunk_length_reg[31:8]};
    assign body_off = chunk_length_reg - bytes_left_reg;

    always_comb begin
        phase_next        = phase_reg;
        magic_ok_next     = magic_ok_reg;
        chunk_tag_next    = chunk_tag_reg;
        chunk_length_next = chunk_length_reg;
        bytes_left_next   = bytes_left_reg;
        pending_next      = pending_reg;
        saved_next        = saved_reg;
        fmt_seen_next     = fmt_seen_reg;
        data_seen_next    = data_seen_reg;
        data_start_next   = data_start_reg;
        data_size_next    = data_size_reg;
        finish            = 1'b0;

        case (phase_reg)
            PH_MAGIC: begin
                if (pos < 32'd4) begin
                    if (file_byte != tag_byte(TAG_RIFF, pos[1:0])) magic_ok_next = 1'b0;
                end else if (pos >= 32'd8 && pos < WALK_START) begin
                    if (file_byte != tag_byte(TAG_WAVE, pos[1:0])) magic_ok_next = 1'b0;
                end
                if (pos >= WALK_START - 32'd1) begin
                    phase_next      = PH_TAG;
                    bytes_left_next = HDR_LEN;
                    chunk_tag_next  = 32'd0;
                end
            end
            PH_TAG: begin
                chunk_tag_next  = {chunk_tag_reg[23:0], file_byte};
                bytes_left_next = bl_dec;
                if (bl_dec == 32'd0) begin
                    phase_next        = PH_SIZE;
                    bytes_left_next   = HDR_LEN;
                    chunk_length_next = 32'd0;
                end
            end
            PH_SIZE: begin
                chunk_length_next = len_new;
                bytes_left_next   = bl_dec;
                if (bl_dec == 32'd0) begin
                    pending_next    = '0;
                    bytes_left_next = len_new;
                    if (len_new == 32'd0) finish = 1'b1;
                    else phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                // the first 16 body bytes build the format record
                for (int i = 0; i < 16; i++) begin
                    if (body_off < FMT_MIN_LEN && body_off[3:0] == 4'(i)) begin
                        pending_next[i*8 +: 8] = pending_reg[i*8 +: 8] | file_byte;
                    end
                end
                bytes_left_next = bl_dec;
                if (bl_dec == 32'd0) finish = 1'b1;
            end
            PH_PAD: begin
                phase_next      = PH_TAG;
                bytes_left_next = HDR_LEN;
                chunk_tag_next  = 32'd0;
            end
            default: begin
            end
        endcase

        if (finish) begin
            if (chunk_tag_reg == TAG_FMT && chunk_length_next >= FMT_MIN_LEN) begin
                saved_next    = pending_next;
                fmt_seen_next = 1'b1;
            end else if (chunk_tag_reg == TAG_DATA) begin
                data_seen_next  = 1'b1;
                data_start_next = pos + 32'd1 - chunk_length_next;
                data_size_next  = chunk_length_next;
            end
            if (fmt_seen_next && data_seen_next) begin
                phase_next = PH_DONE;
            end else if (chunk_length_next[0]) begin
                phase_next = PH_PAD;
            end else begin
                phase_next      = PH_TAG;
                bytes_left_next = HDR_LEN;
                chunk_tag_next  = 32'd0;
            end
        end
    end

    assign byte_count_next = (byte_count_reg != 32'hFFFF_FFFF) ? byte_count_reg + 32'd1
                                                                : byte_count_reg;

    always_comb begin
        res.format_tag     = saved_next[15:0];
        res.channels       = saved_next[31:16];
        res.sample_rate    = saved_next[63:32];
        res.avg_byte_rate  = saved_next[95:64];
        res.block_align    = saved_next[111:96];
        res.sample_bits    = saved_next[127:112];
        res.payload_offset = data_start_next;
        res.payload_length = data_size_next;
        if (byte_count_next < MIN_FILE_LEN) begin
            res.status = ST_SHORT;
        end else if (!magic_ok_next) begin
            res.status = ST_BAD_MAGIC;
        end else if (!fmt_seen_next || !data_seen_next || data_size_next == 32'd0) begin
            res.status = ST_MISSING;
        end else if (saved_next[15:0] != 16'd1) begin
            res.status = ST_NOT_PCM;
        end else begin
            res.status = ST_OK;
        end
    end

    assign res_load = step && is_last;

    always_ff @(posedge aclk) begin
        // after a result everything returns to the reset values for the next file
        if (!aresetn || res_load) begin
            phase_reg        <= PH_MAGIC;
            byte_count_reg   <= 32'd0;
            magic_ok_reg     <= 1'b1;
            chunk_tag_reg    <= 32'd0;
            chunk_length_reg <= 32'd0;
            bytes_left_reg   <= 32'd0;
            pending_reg      <= '0;
            saved_reg        <= '0;
            fmt_seen_reg     <= 1'b0;
            data_seen_reg    <= 1'b0;
            data_start_reg   <= 32'd0;
            data_size_reg    <= 32'd0;
        end else if (step) begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            magic_ok_reg     <= magic_ok_next;
            chunk_tag_reg    <= chunk_tag_next;
            chunk_length_reg <= chunk_length_next;
            bytes_left_reg   <= bytes_left_next;
            pending_reg      <= pending_next;
            saved_reg        <= saved_next;
            fmt_seen_reg     <= fmt_seen_next;
            data_seen_reg    <= data_seen_next;
            data_start_reg   <= data_start_next;
            data_size_reg    <= data_size_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/rwp_result_reg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rwp_result_reg
// Output register holding one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module rwp_result_reg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire rwp_pkg::result_t              res,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rwp_pkg::TdataBits-1:0]      m_tdata
);
    import rwp_pkg::*;

    logic                 valid_reg, valid_next;
    logic [TdataBits-1:0] data_reg;

    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= pack_result(res);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
`default_nettype wire

>>> sv/riff_wave_header_parser.sv
// a byte is held in the input register until it advances; the result of the last
// byte is loaded into the output register and shown on m_tvalid in the cycle after that
// throughput: one byte per cycle while the output register is free or being read;
// every byte stalls in the input register while a result waits unread
// the walker updates its chunk state from the input register as each byte advances
// reset: synchronous active-low aresetn clears the input and output valid flags and
// the parse state; the parse state also returns to reset after each result
`default_nettype none
// ---------------------------------------------------------------------------
// riff_wave_header_parser
// Byte-stream RIFF/WAVE header parser: one status and format result per file.
// ---------------------------------------------------------------------------
module riff_wave_header_parser (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] file_byte
    input  wire logic                          s_tlast,   // is_last
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [2:0] status, [18:3] format_tag, [34:19] channels, [66:35] sample_rate,
    // [98:67] avg_byte_rate, [114:99] block_align, [130:115] sample_bits,
    // [162:131] payload_offset, [194:163] payload_length, [199:195] zero
    output logic [rwp_pkg::TdataBits-1:0]      m_tdata
);
    import rwp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       s_accept;
    logic       advance;
    logic       res_load;
    result_t    res;

    // a byte moves on when the output register is free or being emptied
    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    rwp_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .file_byte (in_byte_reg),
        .is_last   (in_last_reg),
        .res_load  (res_load),
        .res       (res)
    );

    rwp_result_reg u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef ASSERT_OFF
    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !res_load)
        else $error("result overwritten while stalled");

    // a result comes only from a consumed last byte
    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (advance && in_last_reg))
        else $error("result without last byte");

    // every request taken leaves the stage full
    a_stage_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_valid_reg)
        else $error("accepted request lost");

    // loading a result raises the output valid with a known status code
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> (m_tvalid && (m_tdata[2:0] == ST_OK || m_tdata[2:0] == ST_SHORT
            || m_tdata[2:0] == ST_BAD_MAGIC || m_tdata[2:0] == ST_MISSING
            || m_tdata[2:0] == ST_NOT_PCM)))
        else $error("result not presented");
`endif

endmodule
`default_nettype wire
